/* src/bbe_pkg.sv */
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants of the edge-aware 3x3 box blur
// Line store depth, counter widths and the item passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package bbe_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int EW_W       = COL_W + 1;
   localparam int WID_W      = 11;
   localparam int HGT_W      = 13;
   localparam int ROW_W      = 12;
   localparam int PIX_W      = 24;
   localparam int CSR_W      = 13;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic MODE_PIXEL = 1'b0;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             up;
      logic             down;
      logic             left;
      logic             right;
      logic             last;
   } item_type;

   typedef struct packed {
      logic push;
      logic pos_zero;
   } front_stat_type;

endpackage
`default_nettype wire

/* src/box_blur_3x3_edge_aware.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware: streaming 3x3 box blur with border-aware divisor
// Each output pixel is the per-channel rounded mean of its in-frame 3x3
// neighbors; output trails input by one row and one pixel.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  req      in   tvalid / tready    tdata = red, green, blue; tuser = mode
//  rsp      out  tvalid / tready    tdata = red, green, blue; tlast = frame end
//  csr      in   we                 index (0 width, 1 height), wdata
//
//  An item that yields a pixel passes through the back end in order: store
//  read, window shift, sum, 8-step restoring divide, output; other items end
//  after the window shift. A two-entry queue lets the front accept while the
//  back works or a result waits. Reset is synchronous, active high; line
//  stores are not cleared. Stall on rsp holds the result register.
//
`default_nettype none
module box_blur_3x3_edge_aware (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [bbe_pkg::CSR_W-1:0] csr_wdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [23:0]               req_tdata,  // red, green, blue
   input  wire logic                      req_tuser,  // mode: 1 = drain tick
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [23:0]                    rsp_tdata,  // red, green, blue
   output logic                           rsp_tlast   // last pixel of frame
);

   logic                    q_push, q_full, q_pop, q_valid;
   bbe_pkg::item_type       q_in, q_head;
   bbe_pkg::front_stat_type f_stat;

   // classify transfers and track frame position
   bbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in),
      .stat       (f_stat)
   );

   // hold pending items between front and back
   bbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head)
   );

   // window, line stores and averaging
   bbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_item  (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("item pushed into full queue");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> f_stat.pos_zero)
      else $error("register write left frame position set");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (f_stat.push && q_in.emit && q_in.last && !csr_we) |=> f_stat.pos_zero)
      else $error("frame end did not restart position");
`endif

endmodule
`default_nettype wire

/* src/bbe_front.sv */
// ----------------------------------------------------------------------------
// bbe_front: accept and classify
// Hold frame size, track input and output positions, drop stray drain
// ticks, and push one work item per kept transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [bbe_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_tuser,
   input  wire logic [23:0]                   req_tdata,
   input  wire logic                          q_full,
   output logic                               q_push,
   output bbe_pkg::item_type                  q_item,
   output bbe_pkg::front_stat_type            stat
);

   logic [bbe_pkg::WID_W-1:0] width_ff;
   logic [bbe_pkg::HGT_W-1:0] height_ff;
   logic [bbe_pkg::COL_W-1:0] in_col_ff, in_col_in;
   logic [bbe_pkg::HGT_W-1:0] in_row_ff, in_row_in;
   logic [bbe_pkg::COL_W-1:0] out_col_ff, out_col_in;
   logic [bbe_pkg::ROW_W-1:0] out_row_ff, out_row_in;

   logic [bbe_pkg::EW_W-1:0]  eff_w;
   logic [bbe_pkg::HGT_W-1:0] eff_h;
   logic                      drain, take, emit, in_eol, out_eol;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = bbe_pkg::EW_W'(1);
      end else if (int'(width_ff) > bbe_pkg::MAX_WIDTH) begin
         eff_w = bbe_pkg::EW_W'(bbe_pkg::MAX_WIDTH);
      end else begin
         eff_w = bbe_pkg::EW_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = bbe_pkg::HGT_W'(1);
      end else if (int'(height_ff) > bbe_pkg::MAX_HEIGHT) begin
         eff_h = bbe_pkg::HGT_W'(bbe_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign req_tready = !q_full;
   assign drain      = (in_row_ff >= eff_h);
   assign take       = req_tvalid && req_tready;
   assign q_push     = take && (drain || (req_tuser == bbe_pkg::MODE_PIXEL));
   assign emit       = (in_row_ff >= bbe_pkg::HGT_W'(2))
                    || ((in_row_ff == bbe_pkg::HGT_W'(1)) && (in_col_ff != '0));
   assign in_eol     = ({1'b0, in_col_ff} + bbe_pkg::EW_W'(1)) >= eff_w;
   assign out_eol    = ({1'b0, out_col_ff} + bbe_pkg::EW_W'(1)) >= eff_w;

   always_comb begin
      q_item.pix   = drain ? '0 : req_tdata;
      q_item.col   = in_col_ff;
      q_item.emit  = emit;
      q_item.up    = (out_row_ff != '0);
      q_item.down  = ({1'b0, out_row_ff} + bbe_pkg::HGT_W'(1)) < eff_h;
      q_item.left  = (out_col_ff != '0);
      q_item.right = !out_eol;
      q_item.last  = out_eol && (({1'b0, out_row_ff} + bbe_pkg::HGT_W'(1)) == eff_h);

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (emit && q_item.last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else begin
         if (emit) begin
            if (out_eol) begin
               out_col_in = '0;
               out_row_in = out_row_ff + bbe_pkg::ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + bbe_pkg::COL_W'(1);
            end
         end
         if (in_eol) begin
            in_col_in = '0;
            in_row_in = in_row_ff + bbe_pkg::HGT_W'(1);
         end else begin
            in_col_in = in_col_ff + bbe_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= bbe_pkg::WID_W'(640);
         height_ff  <= bbe_pkg::HGT_W'(480);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (csr_we) begin
         // a register write abandons the frame in progress
         if (csr_index == bbe_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= csr_wdata[bbe_pkg::WID_W-1:0];
         end else begin
            height_ff <= csr_wdata;
         end
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (q_push) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   assign stat.push     = q_push;
   assign stat.pos_zero = (in_col_ff == '0) && (in_row_ff == '0)
                       && (out_col_ff == '0) && (out_row_ff == '0);

endmodule
`default_nettype wire

/* src/bbe_queue.sv */
// ----------------------------------------------------------------------------
// bbe_queue: two-entry item queue
// Decouple the classifying front from the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bbe_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output bbe_pkg::item_type      head_item
);

   bbe_pkg::item_type ent_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        cnt_ff;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/bbe_back.sv */
// ----------------------------------------------------------------------------
// bbe_back: line stores, window and averaging
// Read both line stores, shift the window, sum the in-frame neighbors and
// divide by the count, one restoring divider per channel, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bbe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire bbe_pkg::item_type head_item,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic                   rsp_tlast,
   output logic [23:0]            rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_SUM,
      S_DIV,
      S_OUT
   } state_type;

   localparam int SUM_W = 12;
   localparam int REM_W = 13;

   state_type         state_ff;
   bbe_pkg::item_type item_ff;
   logic [2*bbe_pkg::PIX_W-1:0] mem [bbe_pkg::MAX_WIDTH];
   logic [2*bbe_pkg::PIX_W-1:0] rd_ff;
   logic [bbe_pkg::PIX_W-1:0]   win_ff [9];
   logic [REM_W-1:0] rem_ff [3];
   logic [REM_W-1:0] dsh_ff;
   logic [7:0]       quo_ff [3];
   logic [2:0]       step_ff;
   logic             valid_ff;

   logic [SUM_W-1:0] sum [3];
   logic [8:0]       mask;
   logic [1:0]       n_rows, n_cols;
   logic [3:0]       count;

   assign pop = (state_ff == S_IDLE) && head_valid;

   // line stores: older row in the upper half, newer row in the lower half
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= mem[head_item.col];
      end
      if (state_ff == S_SHIFT) begin
         mem[item_ff.col] <= {rd_ff[bbe_pkg::PIX_W-1:0], item_ff.pix};
      end
   end

   always_comb begin
      n_rows = 2'd1 + {1'b0, item_ff.up} + {1'b0, item_ff.down};
      n_cols = 2'd1 + {1'b0, item_ff.left} + {1'b0, item_ff.right};
      count  = {2'b00, n_rows} * {2'b00, n_cols};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = !((r == 0 && !item_ff.up) || (r == 2 && !item_ff.down)
                         || (c == 0 && !item_ff.left) || (c == 2 && !item_ff.right));
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int k = 0; k < 9; k++) begin
            if (mask[k]) begin
               sum[ch] = sum[ch] + SUM_W'(win_ff[k][8*ch +: 8]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  item_ff  <= head_item;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               for (int r = 0; r < 3; r++) begin
                  win_ff[r*3]   <= win_ff[r*3+1];
                  win_ff[r*3+1] <= win_ff[r*3+2];
               end
               win_ff[2] <= rd_ff[2*bbe_pkg::PIX_W-1:bbe_pkg::PIX_W];
               win_ff[5] <= rd_ff[bbe_pkg::PIX_W-1:0];
               win_ff[8] <= item_ff.pix;
               state_ff  <= item_ff.emit ? S_SUM : S_IDLE;
            end
            S_SUM: begin
               // round half up: (2*sum + count) / (2*count)
               for (int ch = 0; ch < 3; ch++) begin
                  rem_ff[ch] <= {sum[ch], 1'b0} + REM_W'(count);
               end
               dsh_ff   <= REM_W'({count, 1'b0}) << 7;
               step_ff  <= 3'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int ch = 0; ch < 3; ch++) begin
                  if (rem_ff[ch] >= dsh_ff) begin
                     rem_ff[ch] <= rem_ff[ch] - dsh_ff;
                     quo_ff[ch] <= {quo_ff[ch][6:0], 1'b1};
                  end else begin
                     quo_ff[ch] <= {quo_ff[ch][6:0], 1'b0};
                  end
               end
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = item_ff.last;
   assign rsp_tdata  = {quo_ff[2], quo_ff[1], quo_ff[0]};

endmodule
`default_nettype wire

/* dv/tb_box_blur_3x3_edge_aware.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware: self-checking bench for the edge-aware box blur
// Drives RGB frames of many sizes plus drain ticks and noise over the
// request stream, predicts every blurred pixel with an in-bench line-store
// model and checks each response transfer, field by field, in order.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware;

   localparam logic MODE_DRAIN = 1'b1;   // request tuser value of a drain tick
   localparam int   SETTLE_CYC = 64;     // idle wait for queued items to drain
   localparam int   HOLD_CYC   = 400;    // length of the long receiver hold-off
   localparam int   ITEM_GOAL  = 1100;   // kept request transfers over the whole run

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_pix_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic                      csr_index = bbe_pkg::CSR_FRAME_WIDTH;
   logic [bbe_pkg::CSR_W-1:0] csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [23:0]               req_tdata = '0;  // red, green, blue (from bit 0 up)
   logic                      req_tuser = bbe_pkg::MODE_PIXEL;  // mode
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [23:0]               rsp_tdata;       // red, green, blue (from bit 0 up)
   logic                      rsp_tlast;       // frame end

   box_blur_3x3_edge_aware u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Blur predictor state: registers, line stores, window and positions.
   // Unwritten store entries only ever land on masked neighbor slots.
   // ------------------------------------------------------------------------
   logic [bbe_pkg::WID_W-1:0] width_reg;
   logic [bbe_pkg::HGT_W-1:0] height_reg;
   logic [bbe_pkg::PIX_W-1:0] older_line [bbe_pkg::MAX_WIDTH];
   logic [bbe_pkg::PIX_W-1:0] newer_line [bbe_pkg::MAX_WIDTH];
   logic [bbe_pkg::PIX_W-1:0] win [9];
   int                        in_col, in_row, out_col, out_row;

   blur_pix_type        blurred_q[$];
   int                  error_count = 0;
   int                  pixels_sent = 0;
   int                  pixels_checked = 0;
   int                  frames_done = 0;
   int                  items_counted = 0;

   bit                  valid_idle = 1'b1;
   bit                  ready_idle = 1'b1;
   int                  hold_requests = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > bbe_pkg::MAX_WIDTH) return bbe_pkg::MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > bbe_pkg::MAX_HEIGHT) return bbe_pkg::MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   function automatic logic [7:0] round_mean(int sum, int count);
      return 8'((2 * sum + count) / (2 * count));
   endfunction

   function automatic void restart_position();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // Advance the predictor by one accepted request; queue a blurred pixel
   // when one falls due. Returns 1 when the block ignores the item.
   function automatic bit blur_advance(logic mode, logic [bbe_pkg::PIX_W-1:0] rgb);
      int          w, h, sr, sg, sb, cnt, col;
      bit          drain, up, down, lf, rt;
      logic [bbe_pkg::PIX_W-1:0] pix, upper, middle, v;
      blur_pix_type res;
      w = active_width();
      h = active_height();
      drain = (in_row >= h);
      if (!drain && mode == MODE_DRAIN) return 1'b1;
      pix = drain ? '0 : rgb;
      col = in_col % bbe_pkg::MAX_WIDTH;
      upper = older_line[col];
      middle = newer_line[col];
      older_line[col] = middle;
      newer_line[col] = pix;
      for (int r = 0; r < 3; r++) begin
         win[r*3] = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = upper;
      win[5] = middle;
      win[8] = pix;
      if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
         up = out_row > 0;
         down = out_row + 1 < h;
         lf = out_col > 0;
         rt = out_col + 1 < w;
         sr = 0; sg = 0; sb = 0; cnt = 0;
         for (int r = 0; r < 3; r++) begin
            if ((r == 0 && !up) || (r == 2 && !down)) continue;
            for (int c = 0; c < 3; c++) begin
               if ((c == 0 && !lf) || (c == 2 && !rt)) continue;
               v = win[r*3+c];
               sr += v[23:16];
               sg += v[15:8];
               sb += v[7:0];
               cnt++;
            end
         end
         res.red = round_mean(sr, cnt);
         res.green = round_mean(sg, cnt);
         res.blue = round_mean(sb, cnt);
         res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
         blurred_q.push_back(res);
         if (res.frame_end) begin
            restart_position();
            return 1'b0;
         end
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      return 1'b0;
   endfunction

   // Send one request transfer; random gaps go in front while idling is on.
   task automatic send_item(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while (valid_idle && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {b, g, r};
      do @(posedge clock); while (!req_tready);
      if (!blur_advance(mode, {r, g, b})) items_counted++;
      if (mode == bbe_pkg::MODE_PIXEL) pixels_sent++;
   endtask

   task automatic send_random_pixel();
      send_item(bbe_pkg::MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Wait until the block is idle, then write one register.
   task automatic write_csr(logic idx, logic [bbe_pkg::CSR_W-1:0] value);
      req_tvalid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bbe_pkg::CSR_FRAME_WIDTH) width_reg = value[bbe_pkg::WID_W-1:0];
      else height_reg = value[bbe_pkg::HGT_W-1:0];
      restart_position();
   endtask

   task automatic set_frame(int w, int h);
      write_csr(bbe_pkg::CSR_FRAME_WIDTH, bbe_pkg::CSR_W'(w));
      write_csr(bbe_pkg::CSR_FRAME_HEIGHT, bbe_pkg::CSR_W'(h));
   endtask

   // Full frame of random pixels followed by the W + 1 flush ticks.
   task automatic send_frame(int noise_pct);
      int n;
      n = active_width() * active_height();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) send_item(MODE_DRAIN, 8'($urandom),
                                                      8'($urandom), 8'($urandom));
         send_random_pixel();
      end
      for (int i = 0; i <= active_width(); i++) begin
         // a pixel past the frame end acts as a flush tick
         if ($urandom_range(99) < noise_pct) send_random_pixel();
         else send_item(MODE_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      frames_done++;
   endtask

   // ------------------------------------------------------------------------
   // Response side: check each transfer, drive tready with random stalls and
   // the long hold-off on request.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      blur_pix_type exp_pix;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (blurred_q.size() == 0) begin
               $display("%0t: unexpected pixel, actual rgb=%h last=%b", $time,
                        rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               exp_pix = blurred_q.pop_front();
               pixels_checked++;
               if (rsp_tdata[7:0] !== exp_pix.red || rsp_tdata[15:8] !== exp_pix.green ||
                   rsp_tdata[23:16] !== exp_pix.blue || rsp_tlast !== exp_pix.frame_end) begin
                  $display({"%0t: mismatch, expected r=%h g=%h b=%h last=%b,",
                            " actual r=%h g=%h b=%h last=%b"},
                           $time, exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.frame_end,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYC;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(ready_idle && $urandom_range(99) < 33);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset sizes: start a 640x480 frame, then abandon it by a register write.
   task automatic test_abandoned_frame();
      for (int i = 0; i < 6; i++) send_random_pixel();
      set_frame(3, 2);
      send_frame(0);
   endtask

   // 3x3 frame of extreme values, a stray flush tick mid-frame, a pixel
   // during the flush.
   task automatic test_directed();
      logic [7:0] v;
      set_frame(3, 3);
      for (int i = 0; i < 9; i++) begin
         v = (i % 2) ? 8'hFF : 8'h00;
         if (i == 4) send_item(MODE_DRAIN, 8'hFF, 8'hFF, 8'hFF);  // ignored
         send_item(bbe_pkg::MODE_PIXEL, v, ~v, (i == 8) ? 8'hFF : v);
      end
      send_item(bbe_pkg::MODE_PIXEL, 8'hAA, 8'h55, 8'hFF);  // acts as a flush tick
      for (int i = 0; i < 3; i++) send_item(MODE_DRAIN, 8'h00, 8'h00, 8'h00);
      frames_done++;
   endtask

   // Register extremes: zero sizes, single pixel, single row and single column,
   // plus an over-range frame that is started and then abandoned.
   task automatic test_size_extremes();
      set_frame(0, 0);
      send_frame(0);
      set_frame(1, 1);
      send_frame(0);
      set_frame(2, 1);
      send_frame(0);
      set_frame(1, 2);
      send_frame(0);
      set_frame(2047, 8191);
      for (int i = 0; i < 5; i++) send_random_pixel();
   endtask

   // Long receiver hold-off while frames keep coming in.
   task automatic test_back_pressure();
      set_frame(4, 4);
      hold_requests++;
      send_frame(0);
      send_frame(0);
   endtask

   // Back-to-back transfers on both sides.
   task automatic test_no_idle();
      valid_idle = 1'b0;
      ready_idle = 1'b0;
      set_frame(5, 3);
      send_frame(0);
      send_frame(0);
      valid_idle = 1'b1;
      ready_idle = 1'b1;
   endtask

   // Random frames, mostly small, some abandoned midway, some noisy.
   task automatic test_random_frames();
      int w, h, cut;
      while (items_counted < ITEM_GOAL) begin
         w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         h = $urandom_range(8, 1);
         set_frame(w, h);
         if ($urandom_range(7) == 0) begin
            cut = $urandom_range(w * h);
            for (int i = 0; i < cut; i++) send_random_pixel();
            continue;
         end
         repeat ($urandom_range(3, 1)) send_frame(($urandom_range(3) == 0) ? 5 : 0);
      end
   endtask

   initial begin
      width_reg = bbe_pkg::WID_W'(640);
      height_reg = bbe_pkg::HGT_W'(480);
      for (int i = 0; i < bbe_pkg::MAX_WIDTH; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      restart_position();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_abandoned_frame();
      test_directed();
      test_size_extremes();
      test_back_pressure();
      test_no_idle();
      test_random_frames();

      req_tvalid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      $display("Covered %0d frames, %0d pixel transfers, %0d blurred pixels checked.",
               frames_done, pixels_sent, pixels_checked);
      $display("Sizes from 1x1 up to 40x8, zero sizes, an abandoned over-range frame, stray ticks.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Drop the run if it hangs.
   initial begin
      #2ms;
      $display("%0t: timeout, %0d pixels still expected", $time, blurred_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
